>>> rtl/varint_length_prefixed_deframer_macros.svh
// Assertion macros used by the deframer parser RTL.
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// When cond holds at a clock edge, prop must hold at the same edge.
`define VLPD_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// When cond holds at a clock edge, prop must hold at the next edge.
`define VLPD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define VLPD_ASSERT_SAME(label, clk, rst, cond, prop, msg)
`define VLPD_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

>>> rtl/vlpd_pkg.sv
// Types and constants of the length-prefixed VarInt deframer.
`default_nettype none

package vlpd_pkg;

  localparam logic [2:0]  LEN_VARINT_MAX_BYTES = 3'd3;
  localparam logic [2:0]  ID_VARINT_MAX_BYTES  = 3'd5;
  localparam logic [20:0] MAX_LENGTH_RESET     = 21'h1FFFFF;
  localparam int          TDATA_WIDTH          = 64;

  typedef enum logic [1:0] {
    PH_LEN = 2'd0,
    PH_ID  = 2'd1,
    PH_PAY = 2'd2
  } parse_phase_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD      = 3'd0,
    KIND_EMPTY        = 3'd1,
    KIND_LEN_TOO_LONG = 3'd2,
    KIND_ID_TOO_LONG  = 3'd3,
    KIND_LEN_BELOW_ID = 3'd4,
    KIND_OVER_MAX     = 3'd5
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  packet_id;
    logic [7:0]   payload_byte;
    logic         last_of_packet;
    logic         proto_phase;
    logic [20:0]  packet_length;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/varint_length_prefixed_deframer.sv
// Path: input register, combinational parser, result register that holds the output beat.
// Throughput: one byte per cycle unless the output stalls; state updates once per byte.
// Bytes that give no beat keep flowing while a beat waits on the output; a byte that
// gives a beat holds the input until the result register can take it.
// Reset (rst, synchronous): parser returns to reading a length, protocol phase to
// handshake, both stream sides empty, max_length to 2097151.
`default_nettype none

module varint_length_prefixed_deframer
  import vlpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [20:0]            cfg_wr_data,    // max_length
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // data_byte[7:0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // packet_id[31:0], payload_byte[39:32], proto_phase[40], packet_length[61:41], zero[63:62]
  output logic [TDATA_WIDTH-1:0]      m_axis_tdata,
  // result_kind[2:0]
  output logic [2:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);

  logic       take;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       out_ready;
  logic       res_valid;
  result_t    res;

  vlpd_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take          (take),
    .byte_valid    (byte_valid),
    .data_byte     (data_byte)
  );

  vlpd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (byte_valid),
    .data_byte   (data_byte),
    .out_ready   (out_ready),
    .take        (take),
    .res_valid   (res_valid),
    .res         (res)
  );

  vlpd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (res_valid),
    .res           (res),
    .can_load      (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/vlpd_in_reg.sv
// Input register that holds one received byte until the parser takes it.
`default_nettype none

module vlpd_in_reg
  import vlpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // data_byte
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      data_byte
);

  assign s_axis_tready = !byte_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      byte_valid <= 1'b1;
    end else if (take) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data_byte <= s_axis_tdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vlpd_parser.sv
// Framing state machine: VarInt length and id decode, payload count, errors.
`default_nettype none

`include "varint_length_prefixed_deframer_macros.svh"

module vlpd_parser
  import vlpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [20:0] cfg_wr_data,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  data_byte,
  input  wire logic        out_ready,
  output logic             take,
  output logic             res_valid,
  output result_t          res
);

  parse_phase_t parse_phase, parse_phase_next;
  logic [31:0]  varint_accum, varint_accum_next;
  logic [2:0]   varint_byte_count, varint_byte_count_next;
  logic [20:0]  length_value, length_value_next;
  logic [20:0]  bytes_remaining, bytes_remaining_next;
  logic [31:0]  current_id, current_id_next;
  logic         protocol_phase, protocol_phase_next;
  logic         packet_phase, packet_phase_next;
  logic [20:0]  max_length;

  logic         more;
  logic [31:0]  shifted;
  logic [31:0]  accum_new;
  logic [2:0]   count_new;
  logic [20:0]  count_ext;
  logic [20:0]  rem_dec;
  logic [20:0]  id_rem;

  // Decisions for the byte at hand.
  logic         err;
  result_kind_t err_kind;
  logic [20:0]  err_len;
  logic         pay_last;
  logic         id_done;
  logic         id_empty;
  logic         len_done;
  logic         produces;

  assign more      = data_byte[7];
  assign accum_new = varint_accum | shifted;
  assign count_new = varint_byte_count + 3'd1;
  assign count_ext = {18'd0, count_new};
  assign rem_dec   = bytes_remaining - 21'd1;
  assign id_rem    = length_value - count_ext;

  always_comb begin
    case (varint_byte_count)
      3'd0:    shifted = {25'd0, data_byte[6:0]};
      3'd1:    shifted = {18'd0, data_byte[6:0], 7'd0};
      3'd2:    shifted = {11'd0, data_byte[6:0], 14'd0};
      3'd3:    shifted = {4'd0, data_byte[6:0], 21'd0};
      3'd4:    shifted = {data_byte[3:0], 28'd0};
      default: shifted = 32'd0;
    endcase
  end

  always_comb begin
    err      = 1'b0;
    err_kind = KIND_LEN_TOO_LONG;
    err_len  = 21'd0;
    pay_last = 1'b0;
    id_done  = 1'b0;
    id_empty = 1'b0;
    len_done = 1'b0;
    produces = 1'b0;
    case (parse_phase)
      PH_PAY: begin
        pay_last = (rem_dec == 21'd0);
        produces = 1'b1;
      end
      PH_ID: begin
        if (more) begin
          if (count_new >= ID_VARINT_MAX_BYTES) begin
            err      = 1'b1;
            err_kind = KIND_ID_TOO_LONG;
            err_len  = length_value;
          end else if (count_ext >= length_value) begin
            err      = 1'b1;
            err_kind = KIND_LEN_BELOW_ID;
            err_len  = length_value;
          end
        end else begin
          id_done  = 1'b1;
          id_empty = (id_rem == 21'd0);
        end
        produces = err || id_empty;
      end
      default: begin
        if (more) begin
          if (count_new >= LEN_VARINT_MAX_BYTES) begin
            err      = 1'b1;
            err_kind = KIND_LEN_TOO_LONG;
          end
        end else if (accum_new > {11'd0, max_length}) begin
          err      = 1'b1;
          err_kind = KIND_OVER_MAX;
          err_len  = accum_new[20:0];
        end else if (accum_new[20:0] == 21'd0) begin
          err      = 1'b1;
          err_kind = KIND_LEN_BELOW_ID;
        end else begin
          len_done = 1'b1;
        end
        produces = err;
      end
    endcase
  end

  // A byte that yields nothing can advance even while the result register is full.
  assign take = byte_valid && (out_ready || !produces);

  // Next state.
  always_comb begin
    parse_phase_next       = parse_phase;
    varint_accum_next      = varint_accum;
    varint_byte_count_next = varint_byte_count;
    length_value_next      = length_value;
    bytes_remaining_next   = bytes_remaining;
    current_id_next        = current_id;
    protocol_phase_next    = protocol_phase;
    packet_phase_next      = packet_phase;
    if (take) begin
      case (parse_phase)
        PH_PAY: begin
          bytes_remaining_next = rem_dec;
          if (pay_last) begin
            parse_phase_next       = PH_LEN;
            varint_accum_next      = 32'd0;
            varint_byte_count_next = 3'd0;
          end
        end
        PH_ID: begin
          varint_accum_next      = accum_new;
          varint_byte_count_next = count_new;
          if (err) begin
            parse_phase_next       = PH_LEN;
            varint_accum_next      = 32'd0;
            varint_byte_count_next = 3'd0;
          end else if (id_done) begin
            current_id_next      = accum_new;
            packet_phase_next    = protocol_phase;
            bytes_remaining_next = id_rem;
            if (accum_new == 32'd0 && !protocol_phase) begin
              protocol_phase_next = 1'b1;
            end
            parse_phase_next       = id_empty ? PH_LEN : PH_PAY;
            varint_accum_next      = 32'd0;
            varint_byte_count_next = 3'd0;
          end
        end
        default: begin
          varint_accum_next      = accum_new;
          varint_byte_count_next = count_new;
          parse_phase_next       = PH_LEN;
          if (!more && !err) begin
            length_value_next = accum_new[20:0];
          end
          if (err || len_done) begin
            parse_phase_next       = err ? PH_LEN : PH_ID;
            varint_accum_next      = 32'd0;
            varint_byte_count_next = 3'd0;
          end
        end
      endcase
    end
  end

  // Result of the byte at hand.
  always_comb begin
    res_valid          = take && produces;
    res.kind           = KIND_PAYLOAD;
    res.packet_id      = 32'd0;
    res.payload_byte   = 8'd0;
    res.last_of_packet = 1'b1;
    res.proto_phase    = protocol_phase;
    res.packet_length  = err_len;
    if (!err) begin
      case (parse_phase)
        PH_PAY: begin
          res.packet_id      = current_id;
          res.payload_byte   = data_byte;
          res.last_of_packet = pay_last;
          res.proto_phase    = packet_phase;
          res.packet_length  = length_value;
        end
        PH_ID: begin
          res.kind          = KIND_EMPTY;
          res.packet_id     = accum_new;
          res.packet_length = length_value;
        end
        default: begin
          res.kind = KIND_PAYLOAD;
        end
      endcase
    end else begin
      res.kind = err_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_LEN;
      varint_accum      <= 32'd0;
      varint_byte_count <= 3'd0;
      length_value      <= 21'd0;
      bytes_remaining   <= 21'd0;
      current_id        <= 32'd0;
      protocol_phase    <= 1'b0;
      packet_phase      <= 1'b0;
    end else begin
      parse_phase       <= parse_phase_next;
      varint_accum      <= varint_accum_next;
      varint_byte_count <= varint_byte_count_next;
      length_value      <= length_value_next;
      bytes_remaining   <= bytes_remaining_next;
      current_id        <= current_id_next;
      protocol_phase    <= protocol_phase_next;
      packet_phase      <= packet_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  `VLPD_ASSERT_SAME(a_pay_nonzero, clk, rst, parse_phase == PH_PAY, bytes_remaining != 21'd0, "payload phase with no bytes left")
  `VLPD_ASSERT_SAME(a_id_fits, clk, rst, parse_phase == PH_ID, {18'd0, varint_byte_count} < length_value, "id bytes already fill the length")
  `VLPD_ASSERT_SAME(a_len_count, clk, rst, parse_phase == PH_LEN, varint_byte_count < LEN_VARINT_MAX_BYTES, "length VarInt count out of range")
  `VLPD_ASSERT_NEXT(a_proto_sticky, clk, rst, protocol_phase, protocol_phase, "protocol phase left login")

endmodule

`default_nettype wire

>>> rtl/vlpd_out_reg.sv
// Result register that presents one result beat on the output stream.
`default_nettype none

module vlpd_out_reg
  import vlpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire result_t                res,
  output logic                        can_load,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // packet_id[31:0], payload_byte[39:32], proto_phase[40], packet_length[61:41], zero[63:62]
  output logic [TDATA_WIDTH-1:0]      m_axis_tdata,
  // result_kind[2:0]
  output logic [2:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);

  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {2'b00, res.packet_length, res.proto_phase, res.payload_byte,
                       res.packet_id};
      m_axis_tuser <= res.kind;
      m_axis_tlast <= res.last_of_packet;
    end
  end

endmodule

`default_nettype wire
